FILE: rtl/bba_pkg.sv
// Shared types and constants for the buddy block allocator.
// Used by bba_core, buddy_block_allocator and tb_top; depends on nothing.
package bba_pkg;

  localparam int LEVELS_DEF     = 10;
  localparam int MAX_ORDER_DEF  = 20;
  localparam int NUM_OWNERS_DEF = 32;

  localparam int OWNER_W  = 5;
  localparam int SIZE_W   = 21;
  localparam int STATUS_W = 3;
  localparam int OFFSET_W = 20;
  localparam int ORDER_W  = 5;
  localparam int CFG_W    = 5;
  // Internal order arithmetic must hold MAX_ORDER up to 32.
  localparam int ORD_W    = 6;

  localparam logic [CFG_W-1:0] TOTAL_ORDER_RST = 5'd20;
  localparam logic [CFG_W-1:0] MIN_ORDER_RST   = 5'd10;

  typedef enum logic [0:0] {
    REG_TOTAL_ORDER = 1'b0,
    REG_MIN_ORDER   = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    NS_ABSENT = 2'd0,
    NS_FREE   = 2'd1,
    NS_SPLIT  = 2'd2,
    NS_USED   = 2'd3
  } node_st_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC     = 3'd0,
    ST_RELEASED  = 3'd1,
    ST_NO_FREE   = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_BAD_OWNER = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SPLIT_A,
    S_SPLIT_B,
    S_MARK,
    S_REL_CHK,
    S_MRG_RD,
    S_MRG_CHK,
    S_MRG_WB,
    S_REL_END,
    S_DONE
  } core_state_t;

  typedef struct packed {
    logic [ORD_W-1:0] t;
    logic [ORD_W-1:0] m;
  } eff_cfg_t;

  typedef struct packed {
    status_t               status;
    logic [OFFSET_W-1:0]   offset;
    logic [ORDER_W-1:0]    order;
  } result_t;

endpackage

FILE: rtl/buddy_block_allocator.sv
// Buddy block allocator: an owner submits a size; the block grants the
// lowest-address free power-of-two block of the rounded order, splitting a
// larger block when needed. A size of zero releases the owner's block and
// merges free buddies upward. One result item per input item.
// Channels: input (in_valid/in_stall, owner_id, request_size) and output
// (out_valid/out_stall, status, block_offset, block_order), each accepted
// when valid is high and stall is low. Configuration writes use cfg_we,
// cfg_index and cfg_data; the user must make them while the block is idle.
// The block does not enforce this. One item at a time: an allocation scans
// nodes from the target level toward the root, marks each split parent and
// frees its right child, then marks the block used; a release checks the
// owner's node, then reads, checks and writes back each merge level. Each
// tree node scanned is one read of the node RAM. Reset, and every write of
// total_order, clears all 2^(LEVELS+1)-1 nodes (2047 by default), in_stall high.
// A finished result sits in the output register while the next item is
// taken; if the receiver stalls, the following result waits in the core.
// Depends on bba_pkg, bba_core and bba_ram.
module buddy_block_allocator import bba_pkg::*; #(
  parameter int LEVELS     = LEVELS_DEF,
  parameter int MAX_ORDER  = MAX_ORDER_DEF,
  parameter int NUM_OWNERS = NUM_OWNERS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OWNER_W-1:0]  owner_id,
  input  logic [SIZE_W-1:0]   request_size,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [OFFSET_W-1:0] block_offset,
  output logic [ORDER_W-1:0]  block_order
);

  logic [CFG_W-1:0] total_order;
  logic [CFG_W-1:0] min_order;
  logic             restart;
  eff_cfg_t         cfg;
  logic             res_valid;
  logic             res_ready;
  result_t          res;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_order <= TOTAL_ORDER_RST;
      min_order   <= MIN_ORDER_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TOTAL_ORDER: total_order <= cfg_data;
        REG_MIN_ORDER:   min_order   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign restart = cfg_we && (cfg_reg_t'(cfg_index) == REG_TOTAL_ORDER);

  // Effective orders: total saturates, and the minimum is kept within
  // LEVELS of the total and never above it.
  always_comb begin
    logic [ORD_W-1:0] t_sat;
    logic [ORD_W-1:0] m0;
    t_sat = (int'(total_order) > MAX_ORDER) ? ORD_W'(MAX_ORDER) : ORD_W'(total_order);
    m0    = (ORD_W'(min_order) > t_sat) ? t_sat : ORD_W'(min_order);
    cfg.t = t_sat;
    cfg.m = (int'(t_sat - m0) > LEVELS) ? t_sat - ORD_W'(LEVELS) : m0;
  end

  bba_core #(
    .LEVELS     (LEVELS),
    .MAX_ORDER  (MAX_ORDER),
    .NUM_OWNERS (NUM_OWNERS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .restart      (restart),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .owner_id     (owner_id),
    .request_size (request_size),
    .res_valid    (res_valid),
    .res          (res),
    .res_ready    (res_ready)
  );

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status       <= res.status;
      block_offset <= res.offset;
      block_order  <= res.order;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NO_FREE || status == ST_TOO_LARGE || status == ST_BAD_OWNER)
    |-> block_offset == '0 && block_order == '0)
    else $error("error result carries a nonzero block");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_BAD_OWNER)
    else $error("result status out of range");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input taken during clearing pass");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> in_stall)
    else $error("input open while a result is pending in the core");

endmodule

FILE: rtl/bba_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// Used for the node status tree; no dependencies.
module bba_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 2047
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/bba_core.sv
// Allocation and release sequencer: owner table, tree scan, split and merge.
// Depends on bba_pkg and drives one bba_ram instance holding the node tree.
module bba_core import bba_pkg::*; #(
  parameter int LEVELS     = LEVELS_DEF,
  parameter int MAX_ORDER  = MAX_ORDER_DEF,
  parameter int NUM_OWNERS = NUM_OWNERS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                restart,
  input  eff_cfg_t            cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OWNER_W-1:0]  owner_id,
  input  logic [SIZE_W-1:0]   request_size,
  output logic                res_valid,
  output result_t             res,
  input  logic                res_ready
);

  localparam int AW    = LEVELS + 1;
  localparam int NODES = (1 << AW) - 1;
  localparam int OW    = (NUM_OWNERS > 1) ? $clog2(NUM_OWNERS) : 1;
  localparam int LW    = $clog2(LEVELS + 1);
  localparam int CW    = (MAX_ORDER + 1 > SIZE_W) ? MAX_ORDER + 1 : SIZE_W;

  function automatic logic [AW-1:0] first_of(input logic [LW-1:0] j);
    return (AW'(1) << j) - AW'(1);
  endfunction

  function automatic logic [AW-1:0] last_of(input logic [LW-1:0] j);
    return (AW'(2) << j) - AW'(2);
  endfunction

  function automatic logic [LW-1:0] depth_of(input logic [AW-1:0] n);
    logic [LW-1:0] d;
    d = '0;
    for (int i = 1; i <= LEVELS; i++) begin
      if (n >= first_of(LW'(i))) d = LW'(i);
    end
    return d;
  endfunction

  function automatic logic [ORD_W-1:0] clog2_of(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] v;
    logic [ORD_W-1:0]  r;
    v = s - SIZE_W'(1);
    r = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if ((v >> i) != '0) r = ORD_W'(i + 1);
    end
    return r;
  endfunction

  core_state_t state, state_next;

  logic [AW-1:0]       clr_addr;
  logic [OWNER_W-1:0]  req_owner;
  logic [SIZE_W-1:0]   req_size;
  logic [NUM_OWNERS-1:0] owner_valid;
  logic [AW-1:0]       owner_node [NUM_OWNERS];
  logic [AW-1:0]       idx;
  logic [LW-1:0]       lvl;
  logic [LW-1:0]       dlvl;
  logic [ORD_W-1:0]    korder;
  logic [AW-1:0]       scan_addr;
  logic [LW-1:0]       scan_lvl;
  logic                scan_go;
  logic                pend_valid;
  logic [AW-1:0]       pend_addr;
  logic [LW-1:0]       pend_lvl;
  status_t             res_status;
  logic [OFFSET_W-1:0] res_offset;
  logic [ORDER_W-1:0]  res_order;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  node_st_t            ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [1:0]          ram_rdata;
  node_st_t            rd_st;

  logic                owner_ok;
  logic [OW-1:0]       oi;
  logic                too_large;
  logic [ORD_W-1:0]    k_calc;
  logic [ORD_W-1:0]    d_calc;
  logic                scan_hit;
  logic                scan_miss;
  logic [AW-1:0]       buddy;
  logic [AW-1:0]       parent;
  logic [LW-1:0]       idx_depth;

  assign rd_st     = node_st_t'(ram_rdata);
  assign owner_ok  = int'(req_owner) < NUM_OWNERS;
  assign oi        = OW'(req_owner);
  assign too_large = CW'(req_size) > (CW'(1) << cfg.t);
  assign scan_hit  = pend_valid && (rd_st == NS_FREE);
  assign scan_miss = pend_valid && (rd_st != NS_FREE) && (pend_addr == '0);
  assign buddy     = idx[0] ? idx + AW'(1) : idx - AW'(1);
  assign parent    = (idx - AW'(1)) >> 1;
  assign idx_depth = depth_of(idx);

  always_comb begin
    logic [ORD_W-1:0] c;
    c = clog2_of(req_size);
    k_calc = (c > cfg.m) ? c : cfg.m;
    d_calc = cfg.t - k_calc;
  end

  bba_ram #(
    .WIDTH (2),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:   if (clr_addr == AW'(NODES - 1)) state_next = S_IDLE;
      S_IDLE:    if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        if (!owner_ok) begin
          state_next = S_DONE;
        end else if (req_size == '0) begin
          state_next = owner_valid[oi] ? S_REL_CHK : S_DONE;
        end else if (owner_valid[oi] || too_large) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_next = (pend_lvl < dlvl) ? S_SPLIT_A : S_MARK;
        end else if (scan_miss) begin
          state_next = S_DONE;
        end
      end
      S_SPLIT_A: state_next = S_SPLIT_B;
      S_SPLIT_B: state_next = (lvl + LW'(1) < dlvl) ? S_SPLIT_A : S_MARK;
      S_MARK:    state_next = S_DONE;
      S_REL_CHK: begin
        if (rd_st != NS_USED) begin
          state_next = S_DONE;
        end else begin
          state_next = (idx == '0) ? S_REL_END : S_MRG_RD;
        end
      end
      S_MRG_RD:  state_next = S_MRG_CHK;
      S_MRG_CHK: state_next = (rd_st == NS_FREE) ? S_MRG_WB : S_REL_END;
      S_MRG_WB:  state_next = (parent == '0) ? S_REL_END : S_MRG_RD;
      S_REL_END: state_next = S_DONE;
      S_DONE:    if (res_ready) state_next = S_IDLE;
      default:   state_next = S_CLEAR;
    endcase
  end

  // Memory port control and handshake outputs.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = NS_ABSENT;
    ram_raddr = idx;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = (clr_addr == '0) ? NS_FREE : NS_ABSENT;
      end
      S_DECODE:  ram_raddr = owner_node[oi];
      S_SCAN:    ram_raddr = scan_addr;
      S_SPLIT_A: begin
        ram_we    = 1'b1;
        ram_wdata = NS_SPLIT;
      end
      S_SPLIT_B: begin
        ram_we    = 1'b1;
        ram_waddr = {idx[AW-2:0], 1'b0} + AW'(2);
        ram_wdata = NS_FREE;
      end
      S_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = NS_USED;
      end
      S_MRG_RD:  ram_raddr = buddy;
      S_MRG_CHK: begin
        ram_we    = (rd_st == NS_FREE);
        ram_wdata = NS_ABSENT;
      end
      S_MRG_WB: begin
        ram_we    = 1'b1;
        ram_waddr = buddy;
        ram_wdata = NS_ABSENT;
      end
      S_REL_END: begin
        ram_we    = 1'b1;
        ram_wdata = NS_FREE;
      end
      default: ;
    endcase
    in_stall  = (state != S_IDLE);
    res_valid = (state == S_DONE);
    res       = '{status: res_status, offset: res_offset, order: res_order};
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      owner_valid <= '0;
      scan_go     <= 1'b0;
      pend_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + AW'(1);
      pend_valid <= (state == S_SCAN) && scan_go && !scan_hit;
      if (state == S_DECODE) begin
        scan_go <= owner_ok && (req_size != '0) && !owner_valid[oi] && !too_large;
        if (owner_ok && (req_size == '0)) owner_valid[oi] <= 1'b0;
      end else if (state == S_SCAN) begin
        if (scan_hit || (scan_go && scan_addr == last_of(scan_lvl) && scan_lvl == '0)) begin
          scan_go <= 1'b0;
        end
      end
      if (state == S_MARK) owner_valid[oi] <= 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    pend_addr <= scan_addr;
    pend_lvl  <= scan_lvl;
    unique case (state)
      S_IDLE: begin
        req_owner <= owner_id;
        req_size  <= request_size;
      end
      S_DECODE: begin
        res_status <= ST_BAD_OWNER;
        res_offset <= '0;
        res_order  <= '0;
        idx        <= owner_node[oi];
        korder     <= k_calc;
        dlvl       <= LW'(d_calc);
        scan_lvl   <= LW'(d_calc);
        scan_addr  <= first_of(LW'(d_calc));
        if (owner_ok && (req_size != '0) && !owner_valid[oi] && too_large) begin
          res_status <= ST_TOO_LARGE;
        end
      end
      S_SCAN: begin
        if (scan_go) begin
          if (scan_addr == last_of(scan_lvl)) begin
            if (scan_lvl != '0) begin
              scan_lvl  <= scan_lvl - LW'(1);
              scan_addr <= first_of(scan_lvl - LW'(1));
            end
          end else begin
            scan_addr <= scan_addr + AW'(1);
          end
        end
        if (scan_hit) begin
          idx <= pend_addr;
          lvl <= pend_lvl;
        end else if (scan_miss) begin
          res_status <= ST_NO_FREE;
        end
      end
      S_SPLIT_B: begin
        idx <= {idx[AW-2:0], 1'b1};
        lvl <= lvl + LW'(1);
      end
      S_MARK: begin
        owner_node[oi] <= idx;
        res_status     <= ST_ALLOC;
        res_order      <= ORDER_W'(korder);
        res_offset     <= OFFSET_W'(idx - first_of(dlvl)) << korder;
      end
      S_REL_CHK: begin
        if (rd_st == NS_USED) begin
          res_status <= ST_RELEASED;
          res_order  <= ORDER_W'(cfg.t - ORD_W'(idx_depth));
          res_offset <= OFFSET_W'(idx - first_of(idx_depth)) << (cfg.t - ORD_W'(idx_depth));
        end
      end
      S_MRG_WB: idx <= parent;
      default: ;
    endcase
  end

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for buddy_block_allocator: directed and random
// allocate/release items, checked against a tree-level allocator model.
// Depends on bba_pkg and the buddy_block_allocator RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int TREE_NODES = 2047;
  localparam int TREE_LEVELS = 10;
  localparam int ORDER_CAP = 20;
  localparam int OWNERS = 32;
  localparam longint CYCLE_LIMIT = 10000000;
  localparam int DRAIN_CYCLES = 3000;

  typedef struct {
    status_t status;
    logic [OFFSET_W-1:0] offset;
    logic [ORDER_W-1:0] order;
  } grant_t;

  class alloc_scoreboard;
    node_st_t tree[TREE_NODES];
    logic [10:0] held_node[OWNERS];
    bit held[OWNERS];
    int unsigned total_cfg;
    int unsigned min_cfg;
    grant_t pending_grants[$];
    int errors;

    function void clear_region();
      foreach (tree[i]) tree[i] = NS_ABSENT;
      tree[0] = NS_FREE;
      foreach (held[i]) begin
        held[i] = 0;
        held_node[i] = '0;
      end
    endfunction

    function new();
      total_cfg = 20;
      min_cfg = 10;
      errors = 0;
      clear_region();
    endfunction

    function void write_reg(cfg_reg_t idx, int unsigned val);
      if (idx == REG_TOTAL_ORDER) begin
        total_cfg = val & 31;
        clear_region();
      end else begin
        min_cfg = val & 31;
      end
    endfunction

    function int unsigned level_of(int unsigned n);
      int unsigned d;
      d = 0;
      while (d < TREE_LEVELS && n >= (2 << d) - 1) d++;
      return d;
    endfunction

    // Computes the grant or release that this item causes and updates the tree.
    function void note_input(int unsigned owner, longint unsigned size);
      grant_t g;
      int unsigned t, m, k, d, j, n, idx, bud, par;
      bit found;
      longint unsigned off;
      g.status = ST_BAD_OWNER;
      off = 0;
      g.order = '0;
      t = (total_cfg > ORDER_CAP) ? ORDER_CAP : total_cfg;
      if (owner < OWNERS) begin
        if (size == 0) begin
          if (held[owner]) begin
            idx = held_node[owner];
            if (idx < TREE_NODES && tree[idx] == NS_USED) begin
              d = level_of(idx);
              g.order = ORDER_W'(t - d);
              off = longint'(idx - ((1 << d) - 1)) << (t - d);
              g.status = ST_RELEASED;
              tree[idx] = NS_FREE;
              while (idx > 0) begin
                bud = (idx & 1) ? idx + 1 : idx - 1;
                par = (idx - 1) >> 1;
                if (tree[bud] != NS_FREE) break;
                tree[idx] = NS_ABSENT;
                tree[bud] = NS_ABSENT;
                tree[par] = NS_FREE;
                idx = par;
              end
            end
            held[owner] = 0;
          end
        end else if (!held[owner]) begin
          if (size > (64'd1 << t)) begin
            g.status = ST_TOO_LARGE;
          end else begin
            m = (min_cfg > t) ? t : min_cfg;
            if (t - m > TREE_LEVELS) m = t - TREE_LEVELS;
            k = m;
            while ((64'd1 << k) < size) k++;
            d = t - k;
            j = d;
            found = 0;
            idx = 0;
            forever begin
              for (n = (1 << j) - 1; n <= (2 << j) - 2; n++) begin
                if (tree[n] == NS_FREE) begin
                  idx = n;
                  found = 1;
                  break;
                end
              end
              if (found || j == 0) break;
              j--;
            end
            if (!found) begin
              g.status = ST_NO_FREE;
            end else begin
              while (j < d) begin
                tree[idx] = NS_SPLIT;
                tree[2 * idx + 1] = NS_FREE;
                tree[2 * idx + 2] = NS_FREE;
                idx = 2 * idx + 1;
                j++;
              end
              tree[idx] = NS_USED;
              held_node[owner] = 11'(idx);
              held[owner] = 1;
              g.status = ST_ALLOC;
              g.order = ORDER_W'(k);
              off = longint'(idx - ((1 << d) - 1)) << k;
            end
          end
        end
      end
      g.offset = off[OFFSET_W-1:0];
      pending_grants.push_back(g);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [OFFSET_W-1:0] off,
                               logic [ORDER_W-1:0] ord);
      grant_t g;
      if (pending_grants.size() == 0) begin
        $error("result item with no expected result: status %0d", st);
        errors++;
        return;
      end
      g = pending_grants.pop_front();
      if (st !== g.status) begin
        $error("status: expected %0d, actual %0d", g.status, st);
        errors++;
      end
      if (off !== g.offset) begin
        $error("block_offset: expected %0h, actual %0h", g.offset, off);
        errors++;
      end
      if (ord !== g.order) begin
        $error("block_order: expected %0d, actual %0d", g.order, ord);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [0:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [OWNER_W-1:0] owner_id = '0;
  logic [SIZE_W-1:0] request_size = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [STATUS_W-1:0] status;
  logic [OFFSET_W-1:0] block_offset;
  logic [ORDER_W-1:0] block_order;

  alloc_scoreboard sb = new();
  bit quiet = 0;
  longint cycles = 0;

  buddy_block_allocator dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** buddy_block_allocator: FAILED **");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_result(status, block_offset, block_order);
      @(negedge clk);
      out_stall <= !quiet && ($urandom_range(0, 99) < 31);
    end
  end

  task automatic write_reg(cfg_reg_t idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, val);
  endtask

  task automatic send_item(int unsigned owner, longint unsigned size);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 31) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    owner_id <= owner[OWNER_W-1:0];
    request_size <= size[SIZE_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(owner, size);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly release-if-held / allocate-if-free, with a share of misuse and noise.
  task automatic random_items(int count, int unsigned t);
    int unsigned o, e, r;
    longint unsigned sz;
    for (int i = 0; i < count; i++) begin
      o = $urandom_range(0, OWNERS - 1);
      r = $urandom_range(0, 99);
      e = $urandom_range(0, t);
      sz = $urandom_range(1, 1 << e);
      if (r < 8) sz = $urandom_range(0, (1 << SIZE_W) - 1);
      else if (r < 14) sz = 0;
      else if (r < 18) sz = (64'd1 << t) + $urandom_range(1, 3);
      else if (sb.held[o]) sz = 0;
      send_item(o, sz);
    end
  endtask

  initial begin
    static int unsigned tot[6] = '{20, 20, 0, 5, 31, 12};
    static int unsigned mn[6] = '{10, 0, 0, 3, 31, 20};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // Directed items at the reset setting: region of 2^20, smallest block 2^10.
    send_item(0, 1);
    send_item(1, 1 << 20);
    send_item(0, 5);
    send_item(2, 0);
    send_item(3, (1 << 20) + 1);
    send_item(4, (1 << SIZE_W) - 1);
    send_item(31, 1024);
    send_item(30, 1025);
    send_item(29, 2048);
    send_item(28, 1 << 19);
    send_item(0, 0);
    send_item(0, 0);
    send_item(31, 0);
    send_item(30, 0);
    send_item(29, 0);
    send_item(28, 0);
    send_item(1, 1 << 20);
    send_item(5, 1);
    send_item(1, 0);
    wait_idle();
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_MIN_ORDER, mn[p]);
      write_reg(REG_TOTAL_ORDER, tot[p]);
      quiet = (p == 1);
      random_items(105, (tot[p] > ORDER_CAP) ? ORDER_CAP : tot[p]);
      wait_idle();
    end
    quiet = 0;
    wait_idle();
    if (sb.errors == 0 && sb.pending_grants.size() == 0)
      $display("** buddy_block_allocator: PASSED **");
    else
      $display("** buddy_block_allocator: FAILED **");
    $finish;
  end
endmodule

FILE: sim.f
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/bba_core.sv
rtl/buddy_block_allocator.sv
bench/tb_top.sv
